// ----- src/fvn_pkg.sv -----
// ---------------------------------------------------------------------------
// fvn_pkg: shared constants and functions of the fractal value noise
// Lattice hash constants, fixed-point widths, register map, blend weight math.
// ---------------------------------------------------------------------------
package fvn_pkg;

  localparam int WEIGHT_BITS = 16;          // Q0.16 weights and amplitudes
  localparam int W_W         = 17;          // weight width, 1.0 included
  localparam int SMOOTH_W    = 36;          // smoothed corner value, scale 2^34
  localparam int WPROD_W     = 54;          // octave value times amplitude
  localparam int SUM_W       = 56;          // octave sum, scale 2^50
  localparam int OUT_W       = 19;          // noise_value, Q2.16
  localparam int OCT_LAT     = 10;          // register stages inside one octave
  localparam int PIPE_LAT    = 13;          // input to output register stages

  localparam logic [31:0] HASH_X57  = 32'd57;
  localparam logic [31:0] HASH_S131 = 32'd131;
  localparam logic [31:0] HASH_MUL  = 32'd15731;
  localparam logic [31:0] HASH_OFF  = 32'd789221;
  localparam logic [31:0] HASH_ADD  = 32'd1376312589;
  localparam logic [31:0] HASH_ONE  = 32'h4000_0000;

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] ONE_Q30   = 64'd1073741824;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

  localparam logic [W_W-1:0]   AMP_ONE    = W_W'(1 << WEIGHT_BITS);
  localparam logic [15:0]      PERS_RESET = 16'd36045;
  localparam logic [SUM_W-1:0] SUM_ROUND  = SUM_W'(64'd1 << 33);

  localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;

  // Register map, one register per 32-bit word
  localparam logic REG_SEED = 1'b0;
  localparam logic REG_PERS = 1'b1;

  // sin^2 of an angle in Q2.30, as a Q0.16 weight (Taylor series, truncating)
  function automatic logic [W_W-1:0] blend_from_angle(input logic [63:0] a);
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sq;
    longint      s;
    a2   = (a * a) >> 30;
    term = a;
    s    = longint'(a);
    for (int i = 0; i < 7; i++) begin
      term = ((term * a2) >> 30) / TAYLOR_DIV[i];
      if (i[0] == 1'b0) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > longint'(ONE_Q30)) begin
      s = longint'(ONE_Q30);
    end
    sq = 64'(s) * 64'(s);
    return W_W'((sq + (64'd1 << 43)) >> 44);
  endfunction

  function automatic logic signed [SMOOTH_W-1:0] sx32(input logic signed [31:0] v);
    return {{(SMOOTH_W-32){v[31]}}, v};
  endfunction

endpackage

// ----- src/fvn_hash.sv -----
// ---------------------------------------------------------------------------
// fvn_hash: four-stage lattice hash
// Mixes a lattice point with the seed and maps the hash to 2^30 - t.
// ---------------------------------------------------------------------------
module fvn_hash
  import fvn_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        x_i,
  input  logic [31:0]        z_i,
  input  logic [31:0]        seed_mix_i,
  output logic signed [31:0] hash_o
);

  logic [31:0] n_raw;
  logic [31:0] n_d, n_q;
  logic [31:0] sq_q, nb_q;
  logic [31:0] p_q, nc_q;
  logic [31:0] t_full;
  logic signed [31:0] hash_q;

  always_comb begin
    n_raw  = x_i + z_i * HASH_X57 + seed_mix_i;
    n_d    = (n_raw << 13) ^ n_raw;
    t_full = nc_q * p_q + HASH_ADD;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      sq_q   <= n_q * n_q;
      nb_q   <= n_q;
      p_q    <= sq_q * HASH_MUL + HASH_OFF;
      nc_q   <= nb_q;
      hash_q <= $signed(HASH_ONE - {1'b0, t_full[30:0]});
    end
  end

  assign hash_o = hash_q;

endmodule

// ----- src/fvn_octave.sv -----
// ---------------------------------------------------------------------------
// fvn_octave: one octave of value noise
// Splits the scaled point, hashes a 4x4 lattice patch, smooths four corners
// and blends them along x, then z, with cosine weights from a constant ROM.
// ---------------------------------------------------------------------------
module fvn_octave
  import fvn_pkg::*;
#(
  parameter int OCT               = 0,
  parameter int FRACTION_BITS     = 16,
  parameter int BLEND_TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [31:0]                coord_x_i,
  input  logic [31:0]                coord_z_i,
  input  logic [31:0]                seed_mix_i,
  output logic signed [SMOOTH_W-1:0] value_o
);

  localparam int IW = $clog2(BLEND_TABLE_DEPTH);
  localparam int PW = FRACTION_BITS + IW + 1;
  localparam logic [63:0] ROM_DIV = 64'(2 * BLEND_TABLE_DEPTH);

  function automatic logic [BLEND_TABLE_DEPTH*W_W-1:0] build_rom();
    logic [BLEND_TABLE_DEPTH*W_W-1:0] r;
    logic [63:0] a;
    r = '0;
    for (int k = 0; k < BLEND_TABLE_DEPTH; k++) begin
      a = (PI_Q30 * 64'(k)) / ROM_DIV;
      r[k*W_W +: W_W] = blend_from_angle(a);
    end
    return r;
  endfunction

  localparam logic [BLEND_TABLE_DEPTH*W_W-1:0] BLEND_ROM = build_rom();

  // Split the point scaled by 2^OCT into lattice integer and table index
  logic [63:0]   px, pz;
  logic [PW-1:0] prod_x, prod_z;
  logic [31:0]   ix_q, iz_q;
  logic [IW-1:0] idx_x_q, idx_z_q;

  always_comb begin
    px     = {{32{coord_x_i[31]}}, coord_x_i} << OCT;
    pz     = {{32{coord_z_i[31]}}, coord_z_i} << OCT;
    prod_x = PW'(px[FRACTION_BITS-1:0]) * PW'(BLEND_TABLE_DEPTH);
    prod_z = PW'(pz[FRACTION_BITS-1:0]) * PW'(BLEND_TABLE_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ix_q    <= px[FRACTION_BITS +: 32];
      iz_q    <= pz[FRACTION_BITS +: 32];
      idx_x_q <= IW'(prod_x >> FRACTION_BITS);
      idx_z_q <= IW'(prod_z >> FRACTION_BITS);
    end
  end

  // Hash the patch x0-1..x0+2 by z0-1..z0+2
  logic signed [31:0] h [16];

  for (genvar gz = 0; gz < 4; gz++) begin : g_hz
    for (genvar gx = 0; gx < 4; gx++) begin : g_hx
      fvn_hash u_hash (
        .clk_i      (clk_i),
        .en_i       (en_i),
        .x_i        (ix_q + 32'(gx - 1)),
        .z_i        (iz_q + 32'(gz - 1)),
        .seed_mix_i (seed_mix_i),
        .hash_o     (h[gz*4+gx])
      );
    end
  end

  // Carry the table indexes alongside the hash stages
  logic [IW-1:0] dx_q [4];
  logic [IW-1:0] dz_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q[0] <= idx_x_q;
      dz_q[0] <= idx_z_q;
      for (int i = 1; i < 4; i++) begin
        dx_q[i] <= dx_q[i-1];
        dz_q[i] <= dz_q[i-1];
      end
    end
  end

  // Smooth the four corners: diagonals 1, sides 2, center 4
  logic signed [SMOOTH_W-1:0] sm [4];

  for (genvar cz = 0; cz < 2; cz++) begin : g_sz
    for (genvar cx = 0; cx < 2; cx++) begin : g_sx
      localparam int C = (cz + 1) * 4 + (cx + 1);
      logic signed [SMOOTH_W-1:0] diag, side, ctr;
      always_comb begin
        diag = sx32(h[C-5]) + sx32(h[C-3]) + sx32(h[C+3]) + sx32(h[C+5]);
        side = sx32(h[C-1]) + sx32(h[C+1]) + sx32(h[C-4]) + sx32(h[C+4]);
        ctr  = sx32(h[C]);
        sm[cz*2+cx] = diag + (side <<< 1) + (ctr <<< 2);
      end
    end
  end

  logic signed [SMOOTH_W-1:0] s_q [4];
  logic [W_W-1:0]             wx_q, wz_q, wz6_q, wz7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        s_q[i] <= sm[i];
      end
      wx_q <= BLEND_ROM[dx_q[3]*W_W +: W_W];
      wz_q <= BLEND_ROM[dz_q[3]*W_W +: W_W];
    end
  end

  // Blend along x, then along z
  logic signed [SMOOTH_W:0]     d0, d1, dz;
  logic signed [SMOOTH_W+18:0]  m0_q, m1_q, mz_q;
  logic signed [SMOOTH_W-1:0]   s00_q, s01_q, i1_q, i2_q, i1b_q, v_q;

  always_comb begin
    d0 = {s_q[1][SMOOTH_W-1], s_q[1]} - {s_q[0][SMOOTH_W-1], s_q[0]};
    d1 = {s_q[3][SMOOTH_W-1], s_q[3]} - {s_q[2][SMOOTH_W-1], s_q[2]};
    dz = {i2_q[SMOOTH_W-1], i2_q} - {i1_q[SMOOTH_W-1], i1_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q  <= d0 * $signed({1'b0, wx_q});
      m1_q  <= d1 * $signed({1'b0, wx_q});
      s00_q <= s_q[0];
      s01_q <= s_q[2];
      wz6_q <= wz_q;

      i1_q  <= s00_q + SMOOTH_W'(m0_q >>> WEIGHT_BITS);
      i2_q  <= s01_q + SMOOTH_W'(m1_q >>> WEIGHT_BITS);
      wz7_q <= wz6_q;

      mz_q  <= dz * $signed({1'b0, wz7_q});
      i1b_q <= i1_q;

      v_q   <= i1b_q + SMOOTH_W'(mz_q >>> WEIGHT_BITS);
    end
  end

  assign value_o = v_q;

endmodule

// ----- src/fractal_value_noise_2d_top.sv -----
// ---------------------------------------------------------------------------
// fractal_value_noise_2d_top: streaming 2D fractal value noise
// Sums OCTAVE_COUNT octaves of cosine-blended value noise per sample point.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: coord_x_i/coord_z_i (signed Q15.16) with in_valid_i; a
//   transaction completes when in_valid_i is high and in_stall_o is low.
//   Output channel: noise_value_o (signed Q2.16, saturated) with out_valid_o;
//   a transaction completes when out_valid_o is high and out_stall_i is low.
//   Throughput: one transaction per cycle on each side unless the output
//   stalls; every octave has its own 16 hash pipelines and blend multipliers,
//   so no hash or blend hardware is shared between octaves.
//   Pipeline: 13 register stages (10 in each octave, then amplitude multiply,
//   octave sum, round and saturate).
//   Stall: the whole pipeline advances on one enable. While the output
//   register holds a result that is stalled, in_stall_o is high and every
//   stage holds; empty output register lets the pipeline advance.
//   Configuration: APB writes to noise_seed (0x0) and octave_persistence
//   (0x4): the user makes them only while the block is idle; the block does
//   not enforce this. Per-octave amplitudes follow persistence through a
//   free-running register chain that settles before new samples use it.
//   Reset: clears valid bits and restores register defaults; no clear pass.
// ---------------------------------------------------------------------------
module fractal_value_noise_2d_top
  import fvn_pkg::*;
#(
  parameter int OCTAVE_COUNT      = 4,
  parameter int FRACTION_BITS     = 16,
  parameter int BLEND_TABLE_DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // sample points
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [31:0]             coord_x_i,
  input  logic [31:0]             coord_z_i,
  // noise results
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] noise_value_o
);

  // Configuration registers
  logic [31:0] seed_q;
  logic [15:0] pers_q;
  logic        cfg_wr;
  logic [31:0] seed_mix;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      pers_q <= PERS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SEED) begin
        seed_q <= pwdata;
      end else begin
        pers_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SEED) begin
      prdata = seed_q;
    end else begin
      prdata = {16'd0, pers_q};
    end
  end

  // Seed term shared by every hash
  assign seed_mix = seed_q * HASH_S131;

  // Amplitude chain: amp[i] = floor(amp[i-1] * persistence / 2^16)
  logic [W_W-1:0] amp [OCTAVE_COUNT];

  assign amp[0] = AMP_ONE;
  for (genvar i = 1; i < OCTAVE_COUNT; i++) begin : g_amp
    logic [W_W-1:0] amp_q;
    logic [W_W+15:0] amp_prod;
    assign amp_prod = (W_W+16)'(amp[i-1]) * (W_W+16)'(pers_q);
    always_ff @(posedge clk_i) begin
      amp_q <= W_W'(amp_prod >> WEIGHT_BITS);
    end
    assign amp[i] = amp_q;
  end

  // Pipeline control: one enable for all stages, valid bits ride along
  logic                advance;
  logic [PIPE_LAT-1:0] vld_q;

  assign advance     = !vld_q[PIPE_LAT-1] || !out_stall_i;
  assign in_stall_o  = !advance;
  assign out_valid_o = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // Octaves
  logic signed [SMOOTH_W-1:0] oct_val [OCTAVE_COUNT];

  for (genvar i = 0; i < OCTAVE_COUNT; i++) begin : g_oct
    fvn_octave #(
      .OCT               (i),
      .FRACTION_BITS     (FRACTION_BITS),
      .BLEND_TABLE_DEPTH (BLEND_TABLE_DEPTH)
    ) u_octave (
      .clk_i      (clk_i),
      .en_i       (advance),
      .coord_x_i  (coord_x_i),
      .coord_z_i  (coord_z_i),
      .seed_mix_i (seed_mix),
      .value_o    (oct_val[i])
    );
  end

  // Weight each octave, sum with rounding, then scale down and saturate
  logic signed [WPROD_W-1:0] wv_q [OCTAVE_COUNT];
  logic signed [SUM_W-1:0]   sum_d, sum_q;
  logic signed [SUM_W-35:0]  res;
  logic signed [OUT_W-1:0]   out_d, out_q;

  always_comb begin
    sum_d = $signed(SUM_ROUND);
    for (int i = 0; i < OCTAVE_COUNT; i++) begin
      sum_d = sum_d + {{(SUM_W-WPROD_W){wv_q[i][WPROD_W-1]}}, wv_q[i]};
    end
    res = sum_q[SUM_W-1:34];
    if (res > (SUM_W-34)'(OUT_MAX)) begin
      out_d = OUT_MAX;
    end else if (res < (SUM_W-34)'(OUT_MIN)) begin
      out_d = OUT_MIN;
    end else begin
      out_d = OUT_W'(res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < OCTAVE_COUNT; i++) begin
        wv_q[i] <= WPROD_W'(oct_val[i] * $signed({1'b0, amp[i]}));
      end
      sum_q <= sum_d;
      out_q <= out_d;
    end
  end

  assign noise_value_o = out_q;

  // A new result only appears from the stage just before the output
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[PIPE_LAT-2]))
    else $error("output valid rose without a valid item in the last stage");

  // A stalled pipeline keeps every valid bit in place
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline valid bits moved while stalled");

  // A seed write lands in the seed register
  a_seed_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (paddr[2] == REG_SEED)) |=> (seed_q == $past(pwdata)))
    else $error("seed write lost");

endmodule

// ----- dv/fractal_value_noise_2d_top_test.sv -----
// ---------------------------------------------------------------------------
// fractal_value_noise_2d_top_test: self-checking bench for the fractal noise top
// Drives sample points through the valid/stall channels under several register
// settings and idle patterns. Every noise result is compared with a fixed-point
// noise calculator that runs inside the bench.
// ---------------------------------------------------------------------------
module fractal_value_noise_2d_top_test
  import fvn_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Byte addresses of the two configuration registers
  localparam logic [2:0] ADDR_SEED = 3'd0;
  localparam logic [2:0] ADDR_PERS = 3'd4;

  // Idle patterns: none, sender gaps, receiver stalls, both
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  localparam int RANDOM_PER_PHASE = 188;
  localparam int DRAIN_CYCLES     = 30;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [31:0]             coord_x_i;
  logic [31:0]             coord_z_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [OUT_W-1:0] noise_value_o;

  fractal_value_noise_2d_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .coord_x_i     (coord_x_i),
    .coord_z_i     (coord_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .noise_value_o (noise_value_o)
  );

  // Bench copy of the registers, the cosine weight table and the result queue
  logic [31:0]             seed_shadow;
  logic [15:0]             pers_shadow;
  logic [W_W-1:0]          cos_weight_rom [256];
  logic signed [OUT_W-1:0] noise_expect_q [$];
  int                      idle_mode;
  int                      mismatch_count;

  typedef struct {
    logic [31:0] x;
    logic [31:0] z;
  } sample_point_t;

  // Directed points: origin, field extremes, lattice edges, fractions near one
  sample_point_t point_table [16] = '{
    '{32'h0000_0000, 32'h0000_0000},
    '{32'h7fff_ffff, 32'h7fff_ffff},
    '{32'h8000_0000, 32'h8000_0000},
    '{32'h7fff_ffff, 32'h8000_0000},
    '{32'h8000_0000, 32'h7fff_ffff},
    '{32'hffff_ffff, 32'hffff_ffff},
    '{32'h0000_ffff, 32'h0000_0000},
    '{32'h0001_0000, 32'h0001_0000},
    '{32'h0000_8000, 32'h0000_8000},
    '{32'h0000_00ff, 32'h0000_ff00},
    '{32'hffff_0000, 32'h0001_ffff},
    '{32'h7fff_0000, 32'h8000_ffff},
    '{32'h5555_5555, 32'haaaa_aaaa},
    '{32'haaaa_aaaa, 32'h5555_5555},
    '{32'h1234_5678, 32'hfedc_ba98},
    '{32'h0000_0001, 32'hffff_0001}
  };

  // ---------------------------------------------------------------------
  // Noise calculator
  // ---------------------------------------------------------------------

  // Wrapping integer hash, mapped to 2^30 - t
  function automatic longint lattice_value(input logic [31:0] x, input logic [31:0] z);
    logic [31:0] n;
    logic [31:0] t;
    n = x + z * 32'd57 + seed_shadow * 32'd131;
    n = (n << 13) ^ n;
    t = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
    return 64'sd1073741824 - longint'({32'd0, t});
  endfunction

  // 3x3 smoothing: diagonals x1, sides x2, center x4 (scale 2^34)
  function automatic longint smoothed_corner(input logic [31:0] x, input logic [31:0] z);
    longint diag;
    longint side;
    diag = lattice_value(x - 1, z - 1) + lattice_value(x + 1, z - 1)
         + lattice_value(x - 1, z + 1) + lattice_value(x + 1, z + 1);
    side = lattice_value(x - 1, z) + lattice_value(x + 1, z)
         + lattice_value(x, z - 1) + lattice_value(x, z + 1);
    return diag + 2 * side + 4 * lattice_value(x, z);
  endfunction

  // sin^2(pi*k/512) in Q0.16 via truncating Taylor series in Q2.30
  function automatic logic [W_W-1:0] cos_weight(input int k);
    logic [63:0] angle;
    logic [63:0] angle_sq;
    logic [63:0] term;
    logic [63:0] sq;
    longint      acc;
    angle    = (64'd3373259426 * 64'(k)) / 64'd512;
    angle_sq = (angle * angle) >> 30;
    term     = angle;
    acc      = longint'(angle);
    for (int i = 1; i <= 7; i++) begin
      term = ((term * angle_sq) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sd1073741824) acc = 64'sd1073741824;
    sq = 64'(acc) * 64'(acc);
    return W_W'((sq + (64'd1 << 43)) >> 44);
  endfunction

  function automatic longint blend_lerp(input longint a, input longint b, input longint w);
    return a + (((b - a) * w) >>> 16);
  endfunction

  // One octave at a Q.16 point: four smoothed corners, blended along x then z
  function automatic longint octave_sample(input longint px, input longint pz);
    longint      ix;
    longint      iz;
    longint      wx;
    longint      wz;
    logic [31:0] x0;
    logic [31:0] z0;
    longint      row0;
    longint      row1;
    ix   = px >>> 16;
    iz   = pz >>> 16;
    wx   = longint'(cos_weight_rom[(px & 64'hffff) >> 8]);
    wz   = longint'(cos_weight_rom[(pz & 64'hffff) >> 8]);
    x0   = ix[31:0];
    z0   = iz[31:0];
    row0 = blend_lerp(smoothed_corner(x0, z0), smoothed_corner(x0 + 1, z0), wx);
    row1 = blend_lerp(smoothed_corner(x0, z0 + 1), smoothed_corner(x0 + 1, z0 + 1), wx);
    return blend_lerp(row0, row1, wz);
  endfunction

  // Four octaves, amplitude scaled by persistence, rounded half up and saturated
  function automatic logic signed [OUT_W-1:0] predict_noise(input logic [31:0] x,
                                                             input logic [31:0] z);
    longint cx;
    longint cz;
    longint amp;
    longint total;
    longint res;
    cx    = longint'(signed'(x));
    cz    = longint'(signed'(z));
    amp   = 65536;
    total = 0;
    for (int i = 0; i < 4; i++) begin
      total = total + octave_sample(cx <<< i, cz <<< i) * amp;
      amp   = (amp * longint'({48'd0, pers_shadow})) >> 16;
    end
    res = (total + (64'sd1 << 33)) >>> 34;
    if (res > 262143) res = 262143;
    if (res < -262144) res = -262144;
    return OUT_W'(res);
  endfunction

  // ---------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall at the falling edge, check at the rising edge
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (idle_mode == IDLE_RECV) begin
      out_stall_i <= ($urandom_range(0, 99) < 75);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall_i <= ($urandom_range(0, 99) < 32);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    logic signed [OUT_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected noise transaction: got %0d", noise_value_o);
        end
      end else begin
        want = noise_expect_q.pop_front();
        if (noise_value_o !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("noise_value mismatch: expected %0d got %0d", want, noise_value_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender and configuration tasks, called at a falling edge
  // ---------------------------------------------------------------------

  // Offer one sample point; predict its noise once the transaction is taken
  task automatic send_point(input logic [31:0] x, input logic [31:0] z);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 75 : (idle_mode == IDLE_BOTH) ? 32 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= x;
    coord_z_i  <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    noise_expect_q = {noise_expect_q, predict_noise(x, z)};
    @(negedge clk_i);
  endtask

  // Hold until every result is back, then keep the input idle for the drain time
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (noise_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write a register, then read it back and compare with the shadow copy
  task automatic apb_write_check(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_SEED) begin
      seed_shadow = data;
    end else begin
      pers_shadow = data[15:0];
    end
    want = (addr == ADDR_SEED) ? seed_shadow : {16'd0, pers_shadow};
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("register readback at %0h: expected %h got %h", addr, want, prdata);
      end
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random point: full range, near origin, lattice edges, extreme lattice
  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
      2:       return {16'($urandom_range(0, 65535)), 8'hff, 8'($urandom())};
      default: return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [31:0] phase_seed [5];
    logic [31:0] phase_pers [5];
    int          phase_idle [5];

    // Phase settings: defaults, all ones (upper persistence bits dropped),
    // most negative seed with zero persistence, random, largest seed
    phase_seed = '{32'd0, 32'hffff_ffff, 32'h8000_0000, $urandom(), 32'h7fff_ffff};
    phase_pers = '{32'd36045, 32'hffff_ffff, 32'h0000_0000, $urandom(), 32'h0001_8000};
    phase_idle = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};

    for (int k = 0; k < 256; k++) cos_weight_rom[k] = cos_weight(k);
    seed_shadow    = 32'd0;
    pers_shadow    = PERS_RESET;
    mismatch_count = 0;
    idle_mode      = IDLE_NONE;

    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = ADDR_SEED;
    pwdata      = 32'd0;
    in_valid_i  = 1'b0;
    coord_x_i   = 32'd0;
    coord_z_i   = 32'd0;
    out_stall_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < 5; p++) begin
      // Reconfigure only with the pipeline empty; phase 0 runs on reset values
      if (p > 0) begin
        drain_pipeline();
        apb_write_check(ADDR_SEED, phase_seed[p]);
        apb_write_check(ADDR_PERS, phase_pers[p]);
      end
      idle_mode = phase_idle[p];
      if (p == 0 || p == 2) begin
        foreach (point_table[i]) send_point(point_table[i].x, point_table[i].z);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_point(random_coord(), random_coord());
      end
    end

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- fractal_value_noise_2d_top.f -----
src/fvn_pkg.sv
src/fvn_hash.sv
src/fvn_octave.sv
src/fractal_value_noise_2d_top.sv
dv/fractal_value_noise_2d_top_test.sv
